FILE: rtl/pldc_pkg.sv
// Shared types, constants and helpers for the power level duty cycler.
// No dependencies; imported by every other RTL file of the block.
`default_nettype none

package pldc_pkg;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned CYCLE_W  = 16;
  localparam int unsigned MODE_W   = 2;

  // Level range: MIN_LEVEL stays idle, MAX_LEVEL stays on, both untimed
  localparam int unsigned MAX_LEVEL = 10;
  localparam int unsigned MIN_LEVEL = 0;

  localparam logic [CYCLE_W-1:0] CYCLE_TICKS_RST = 16'd10000;

  // level * cycle / MAX_LEVEL as cycle * (level * RECIP) >> RECIP_SHIFT.
  // The product level * cycle stays below 2^20, so a 24-bit shift with the
  // rounded-up reciprocal gives the exact truncated quotient.
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = ((2 ** RECIP_SHIFT) + MAX_LEVEL - 1) / MAX_LEVEL;
  localparam int unsigned SCALE_W     = RECIP_SHIFT + 1;
  localparam int unsigned LVL_STATES  = 2 ** LEVEL_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ON    = 2'd1;
  localparam logic [OP_W-1:0] OP_OFF   = 2'd2;
  localparam logic [OP_W-1:0] OP_PAUSE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [LEVEL_W-1:0] power_level;
  } pldc_in_t;

  typedef struct packed {
    logic               heater_on;
    logic               pattern_valid;
    logic [LEVEL_W-1:0] pattern_index;
    logic [MODE_W-1:0]  mode;
  } pldc_out_t;

  // Phase times for the level carried by the current item
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               timed;
    logic [CYCLE_W-1:0] on_ticks;
    logic [CYCLE_W-1:0] off_ticks;
  } pldc_times_t;

  function automatic logic has_timer(input logic [LEVEL_W-1:0] lvl);
    has_timer = (lvl > LEVEL_W'(MIN_LEVEL)) && (lvl < LEVEL_W'(MAX_LEVEL));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pldc_times.sv
// On/off phase time calculation: level saturation and one constant-reciprocal multiply.
// Depends on pldc_pkg.
`default_nettype none

module pldc_times (
  input  wire logic [pldc_pkg::LEVEL_W-1:0] req_level,
  input  wire logic [pldc_pkg::CYCLE_W-1:0] cycle_ticks,
  output pldc_pkg::pldc_times_t             times
);
  import pldc_pkg::*;

  localparam int unsigned PROD_W = CYCLE_W + SCALE_W;

  logic [LEVEL_W-1:0] lvl_sat;
  logic [SCALE_W-1:0] scale_tab [LVL_STATES];
  logic [PROD_W-1:0]  prod;
  logic [CYCLE_W-1:0] on_t;

  // level * RECIP, constant per level
  for (genvar g = 0; g < LVL_STATES; g++) begin : g_scale
    assign scale_tab[g] = SCALE_W'(g * RECIP);
  end

  assign lvl_sat = (req_level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : req_level;
  assign prod    = PROD_W'(cycle_ticks) * PROD_W'(scale_tab[lvl_sat]);
  assign on_t    = prod[RECIP_SHIFT +: CYCLE_W];

  assign times.level     = lvl_sat;
  assign times.timed     = has_timer(lvl_sat);
  assign times.on_ticks  = on_t;
  assign times.off_ticks = cycle_ticks - on_t;

endmodule

`default_nettype wire

FILE: rtl/pldc_fsm.sv
// Phase state machine: mode, remembered phase, level, phase times and tick counter.
// Depends on pldc_pkg; phase times come from pldc_times.
`default_nettype none

module pldc_fsm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  item_fire,
  input  wire pldc_pkg::pldc_in_t    item,
  input  wire pldc_pkg::pldc_times_t times,
  output pldc_pkg::pldc_out_t        result
);
  import pldc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    ST_OFF   = 2'd0,
    ST_RUN   = 2'd1,
    ST_IDLE  = 2'd2,
    ST_PAUSE = 2'd3
  } state_t;

  state_t             state_r, state_nxt;
  logic               resume_r, resume_nxt;
  logic               armed_r, armed_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [CYCLE_W-1:0] on_r, on_nxt;
  logic [CYCLE_W-1:0] off_r, off_nxt;
  logic [CYCLE_W-1:0] count_r, count_nxt;
  logic               pvalid;
  logic [LEVEL_W-1:0] pidx;
  logic               active;

  assign active = (state_r == ST_RUN) || (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    resume_nxt = resume_r;
    armed_nxt  = armed_r;
    level_nxt  = level_r;
    on_nxt     = on_r;
    off_nxt    = off_r;
    count_nxt  = count_r;
    pvalid     = 1'b0;
    pidx       = '0;
    unique case (item.operation)
      OP_TICK: begin
        if (active && armed_r) begin
          count_nxt = count_r - CYCLE_W'(1);
          if (count_r <= CYCLE_W'(1)) begin
            if (state_r == ST_RUN) begin
              count_nxt  = off_r;
              state_nxt  = ST_IDLE;
              resume_nxt = 1'b0;
            end else begin
              count_nxt  = on_r;
              state_nxt  = ST_RUN;
              resume_nxt = 1'b1;
              pvalid     = 1'b1;
              pidx       = level_r - LEVEL_W'(1);
            end
          end
        end
      end
      OP_ON: begin
        if (state_r == ST_PAUSE) begin
          // resume remembered phase, own level ignored
          if (level_r > LEVEL_W'(MIN_LEVEL)) begin
            armed_nxt = has_timer(level_r);
            if (resume_r) begin
              pvalid = 1'b1;
              pidx   = level_r - LEVEL_W'(1);
            end
          end else begin
            armed_nxt = 1'b0;
          end
          state_nxt = resume_r ? ST_RUN : ST_IDLE;
        end else begin
          level_nxt = times.level;
          armed_nxt = 1'b0;
          if (times.level > LEVEL_W'(MIN_LEVEL)) begin
            if (times.timed) begin
              on_nxt    = times.on_ticks;
              off_nxt   = times.off_ticks;
              count_nxt = times.on_ticks;
              armed_nxt = 1'b1;
            end
            pvalid     = 1'b1;
            pidx       = times.level - LEVEL_W'(1);
            state_nxt  = ST_RUN;
            resume_nxt = 1'b1;
          end else begin
            state_nxt  = ST_IDLE;
            resume_nxt = 1'b0;
          end
        end
      end
      OP_OFF: begin
        armed_nxt = 1'b0;
        state_nxt = ST_OFF;
      end
      OP_PAUSE: begin
        if (active) begin
          armed_nxt = 1'b0;
          state_nxt = ST_PAUSE;
        end
      end
      default: ;
    endcase
  end

  assign result.heater_on     = (state_nxt == ST_RUN);
  assign result.pattern_valid = pvalid;
  assign result.pattern_index = pidx;
  assign result.mode          = state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_OFF;
      resume_r <= 1'b0;
      armed_r  <= 1'b0;
      level_r  <= '0;
      on_r     <= '0;
      off_r    <= '0;
      count_r  <= '0;
    end else if (item_fire) begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      armed_r  <= armed_nxt;
      level_r  <= level_nxt;
      on_r     <= on_nxt;
      off_r    <= off_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_armed_level: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> has_timer(level_r))
    else $error("timer armed for an untimed level");

  a_pause_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAUSE) |-> !armed_r)
    else $error("timer armed while paused");

  a_off_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.operation == OP_OFF) |=> (state_r == ST_OFF) && !armed_r)
    else $error("off request did not stop the block");

  a_pattern_running: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && result.pattern_valid) |=> (state_r == ST_RUN) && resume_r)
    else $error("pattern issued without entering running phase");
`endif

endmodule

`default_nettype wire

FILE: rtl/power_level_duty_cycler_core.sv
// Top level of the power level duty cycler: input register, phase logic, result register.
// Depends on pldc_pkg, pldc_times and pldc_fsm.
// Path: an accepted item waits in the input register, and its result moves into the result
// register once that register is empty or being emptied. Throughput: one item per cycle
// while out_ready is high; the phase logic is a single pass from input to result.
// Reset (rst_n low, synchronous): both item registers empty, mode off, timer disarmed,
// cycle_ticks back to 10000. No clearing pass; the block is ready the cycle after reset.
`default_nettype none

module power_level_duty_cycler_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input items
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire pldc_pkg::pldc_in_t           in_data,
  // result items
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      pldc_pkg::pldc_out_t          out_data,
  // cycle_ticks register write
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [pldc_pkg::CYCLE_W-1:0] cfg_data
);
  import pldc_pkg::*;

  logic               in_valid_r;
  pldc_in_t           in_data_r;
  logic               out_valid_r;
  pldc_out_t          out_data_r;
  logic [CYCLE_W-1:0] cycle_ticks_r;
  logic               advance;
  pldc_times_t        times;
  pldc_out_t          result;

  // An item moves on when the result register is empty or being emptied.
  // A waiting result holds the item in the input register; the input only
  // stalls once that register is full as well.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Phase times from the requested level and the current cycle length
  pldc_times u_times (
    .req_level   (in_data_r.power_level),
    .cycle_ticks (cycle_ticks_r),
    .times       (times)
  );

  // Mode, timer and pattern logic; state updates only as an item advances
  pldc_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (advance),
    .item      (in_data_r),
    .times     (times),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cycle_ticks_r <= CYCLE_TICKS_RST;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        cycle_ticks_r <= cfg_data;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire
